/* rtl/ubx_pkg.sv */
// Shared types and codes for the UBX frame parser.
// Holds the configuration and result record types and the event codes.
// No dependencies.
`default_nettype none

package ubx_pkg;

   // Field widths of the frame record.
   localparam int ByteWidth  = 8;
   localparam int WordWidth  = 16;
   localparam int EventWidth = 2;
   localparam int CsrIdxWidth = 2;

   // Configuration register indexes.
   localparam logic [CsrIdxWidth-1:0] CSR_SYNC_FIRST  = 2'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_SYNC_SECOND = 2'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_MAX_LENGTH  = 2'd2;

   // Reset values of the configuration registers.
   localparam logic [ByteWidth-1:0] SYNC_FIRST_RESET  = 8'hB5;
   localparam logic [ByteWidth-1:0] SYNC_SECOND_RESET = 8'h62;
   localparam logic [WordWidth-1:0] MAX_LENGTH_RESET  = 16'd1024;

   // Event codes reported on the result channel.
   localparam logic [EventWidth-1:0] EV_PAYLOAD  = 2'd0;
   localparam logic [EventWidth-1:0] EV_GOOD     = 2'd1;
   localparam logic [EventWidth-1:0] EV_BAD_SUM  = 2'd2;
   localparam logic [EventWidth-1:0] EV_TOO_LONG = 2'd3;

   typedef struct packed {
      logic [ByteWidth-1:0] sync_first;
      logic [ByteWidth-1:0] sync_second;
      logic [WordWidth-1:0] max_length;
   } cfg_type;

   typedef struct packed {
      logic [EventWidth-1:0] event_res;
      logic [ByteWidth-1:0]  msg_class;
      logic [ByteWidth-1:0]  msg_id;
      logic [WordWidth-1:0]  payload_length;
      logic [WordWidth-1:0]  byte_index;
      logic [ByteWidth-1:0]  byte_value;
   } result_type;

endpackage

`default_nettype wire

/* rtl/ubx_csr.sv */
// Configuration registers of the UBX frame parser.
// Depends on ubx_pkg for the register indexes, reset values and cfg_type.
`default_nettype none

module ubx_csr (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_write_enable,
   input  wire logic [ubx_pkg::CsrIdxWidth-1:0]     csr_index,
   input  wire logic [ubx_pkg::WordWidth-1:0]       csr_write_data,
   output      ubx_pkg::cfg_type                    cfg
);
   import ubx_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Decode the register index; indexes beyond the list leave everything alone.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_SYNC_FIRST:  cfg_in.sync_first  = csr_write_data[ByteWidth-1:0];
            CSR_SYNC_SECOND: cfg_in.sync_second = csr_write_data[ByteWidth-1:0];
            CSR_MAX_LENGTH:  cfg_in.max_length  = csr_write_data;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync_first  <= SYNC_FIRST_RESET;
         cfg_ff.sync_second <= SYNC_SECOND_RESET;
         cfg_ff.max_length  <= MAX_LENGTH_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

/* rtl/ubx_parse_core.sv */
// Frame state machine of the UBX parser: sync hunt, header capture,
// payload streaming and 8-bit Fletcher checksum. Depends on ubx_pkg.
`default_nettype none

module ubx_parse_core (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            accept,
   input  wire logic [ubx_pkg::ByteWidth-1:0]   rx_byte,
   input  wire ubx_pkg::cfg_type                cfg,
   output logic                                 res_valid,
   output ubx_pkg::result_type                  res
);
   import ubx_pkg::*;

   // Parser state codes; unused codes behave as unsynced.
   localparam logic [3:0] ST_UNSYNCED  = 4'd0;
   localparam logic [3:0] ST_GOT_SYNC1 = 4'd1;
   localparam logic [3:0] ST_GOT_SYNC2 = 4'd2;
   localparam logic [3:0] ST_GOT_CLASS = 4'd3;
   localparam logic [3:0] ST_GOT_ID    = 4'd4;
   localparam logic [3:0] ST_GOT_LEN_L = 4'd5;
   localparam logic [3:0] ST_PAYLOAD   = 4'd6;
   localparam logic [3:0] ST_CHECK_A   = 4'd7;
   localparam logic [3:0] ST_CHECK_B   = 4'd8;

   logic [3:0]           state_ff,   state_in;
   logic [ByteWidth-1:0] class_ff,   class_in;
   logic [ByteWidth-1:0] id_ff,      id_in;
   logic [WordWidth-1:0] length_ff,  length_in;
   logic [WordWidth-1:0] count_ff,   count_in;
   logic [ByteWidth-1:0] sum_a_ff,   sum_a_in;
   logic [ByteWidth-1:0] sum_b_ff,   sum_b_in;
   logic [ByteWidth-1:0] check_a_ff, check_a_in;

   logic [ByteWidth-1:0] add_a;
   logic [ByteWidth-1:0] add_b;
   logic [WordWidth-1:0] count_inc;
   logic [WordWidth-1:0] full_length;

   // Running Fletcher sum with the current byte folded in.
   assign add_a       = sum_a_ff + rx_byte;
   assign add_b       = sum_b_ff + add_a;
   assign count_inc   = count_ff + 16'd1;
   assign full_length = {rx_byte, length_ff[ByteWidth-1:0]};

   // Next state and the result that this byte produces, if any.
   always_comb begin
      state_in   = state_ff;
      class_in   = class_ff;
      id_in      = id_ff;
      length_in  = length_ff;
      count_in   = count_ff;
      sum_a_in   = sum_a_ff;
      sum_b_in   = sum_b_ff;
      check_a_in = check_a_ff;
      res_valid  = 1'b0;
      res.event_res  = EV_PAYLOAD;
      res.byte_index = '0;
      res.byte_value = '0;

      case (state_ff)
         ST_GOT_SYNC1: begin
            state_in = (rx_byte == cfg.sync_second) ? ST_GOT_SYNC2 : ST_UNSYNCED;
         end
         ST_GOT_SYNC2: begin
            class_in  = rx_byte;
            id_in     = '0;
            length_in = '0;
            count_in  = '0;
            sum_a_in  = rx_byte;
            sum_b_in  = rx_byte;
            state_in  = ST_GOT_CLASS;
         end
         ST_GOT_CLASS: begin
            id_in    = rx_byte;
            sum_a_in = add_a;
            sum_b_in = add_b;
            state_in = ST_GOT_ID;
         end
         ST_GOT_ID: begin
            length_in = {{ByteWidth{1'b0}}, rx_byte};
            sum_a_in  = add_a;
            sum_b_in  = add_b;
            state_in  = ST_GOT_LEN_L;
         end
         ST_GOT_LEN_L: begin
            length_in = full_length;
            sum_a_in  = add_a;
            sum_b_in  = add_b;
            count_in  = '0;
            if (full_length > cfg.max_length) begin
               state_in      = ST_UNSYNCED;
               res_valid     = 1'b1;
               res.event_res = EV_TOO_LONG;
            end else if (full_length == '0) begin
               state_in = ST_CHECK_A;
            end else begin
               state_in = ST_PAYLOAD;
            end
         end
         ST_PAYLOAD: begin
            sum_a_in       = add_a;
            sum_b_in       = add_b;
            res_valid      = 1'b1;
            res.event_res  = EV_PAYLOAD;
            res.byte_index = count_ff;
            res.byte_value = rx_byte;
            if (count_inc >= length_ff) begin
               count_in = '0;
               state_in = ST_CHECK_A;
            end else begin
               count_in = count_inc;
            end
         end
         ST_CHECK_A: begin
            check_a_in = rx_byte;
            state_in   = ST_CHECK_B;
         end
         ST_CHECK_B: begin
            state_in  = ST_UNSYNCED;
            res_valid = 1'b1;
            if (check_a_ff == sum_a_ff && rx_byte == sum_b_ff) begin
               res.event_res = EV_GOOD;
            end else begin
               res.event_res = EV_BAD_SUM;
            end
         end
         default: begin
            state_in = (rx_byte == cfg.sync_first) ? ST_GOT_SYNC1 : ST_UNSYNCED;
         end
      endcase

      // Header fields as they stand after this byte.
      res.msg_class      = class_in;
      res.msg_id         = id_in;
      res.payload_length = length_in;
   end

   // State advances only on an accepted transfer.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_UNSYNCED;
         class_ff   <= '0;
         id_ff      <= '0;
         length_ff  <= '0;
         count_ff   <= '0;
         sum_a_ff   <= '0;
         sum_b_ff   <= '0;
         check_a_ff <= '0;
      end else if (accept) begin
         state_ff   <= state_in;
         class_ff   <= class_in;
         id_ff      <= id_in;
         length_ff  <= length_in;
         count_ff   <= count_in;
         sum_a_ff   <= sum_a_in;
         sum_b_ff   <= sum_b_in;
         check_a_ff <= check_a_in;
      end
   end

   // A payload phase never starts for an empty frame.
   a_payload_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_PAYLOAD |-> length_ff != '0)
      else $error("payload phase entered with zero length");

   // The payload index stays inside the declared length.
   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_PAYLOAD |-> count_ff < length_ff)
      else $error("payload index beyond declared length");

   // The second checksum byte always closes the frame.
   a_check_b_closes: assert property (@(posedge clock) disable iff (reset)
      accept && state_ff == ST_CHECK_B |=> state_ff == ST_UNSYNCED)
      else $error("frame not closed after checksum");

   // Results only arise from the payload, length and checksum states.
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> (state_ff == ST_PAYLOAD || state_ff == ST_GOT_LEN_L ||
                     state_ff == ST_CHECK_B))
      else $error("result raised from an unexpected state");

endmodule

`default_nettype wire

/* rtl/ubx_rsp_reg.sv */
// Result register of the UBX frame parser: holds one result until the
// receiver takes it. Depends on ubx_pkg for result_type.
`default_nettype none

module ubx_rsp_reg (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 accept,
   input  wire logic                 res_valid,
   input  wire ubx_pkg::result_type  res,
   input  wire logic                 rsp_stall,
   output logic                      rsp_valid,
   output ubx_pkg::result_type       rsp_data,
   output logic                      req_stall
);
   import ubx_pkg::*;

   logic       valid_ff, valid_in;
   result_type data_ff;

   // The input side waits only while a held result is itself stalled.
   assign req_stall = valid_ff & rsp_stall;

   // A new byte replaces the slot; otherwise the slot drains once taken.
   assign valid_in = accept ? res_valid : (valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload register needs no reset.
   always_ff @(posedge clock) begin
      if (accept && res_valid) begin
         data_ff <= res;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   // A result that is stalled is still there in the next cycle.
   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      valid_ff && rsp_stall |=> valid_ff)
      else $error("stalled result lost");

   // No byte is taken while the held result is stalled.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      valid_ff && rsp_stall |-> !accept)
      else $error("result slot overwritten while stalled");

   // A stalled result keeps its contents.
   a_hold_data: assert property (@(posedge clock) disable iff (reset)
      valid_ff && rsp_stall |=> $stable(data_ff))
      else $error("stalled result changed");

endmodule

`default_nettype wire

/* rtl/ubx_frame_parser_top.sv */
// UBX frame parser, top level. Instantiates the configuration registers,
// the frame state machine and the result register. Depends on ubx_pkg.
//
// Usage: one received byte is offered per transfer on the req_ channel
// (req_valid, req_stall, req_rx_byte). The parser hunts for the two sync
// bytes, captures class, id and the little-endian length, streams each
// payload byte out with its index, and ends each frame with a good or bad
// checksum event. A frame whose length exceeds the configured maximum gives
// a single drop event and the parser resumes hunting.
// Results leave on the rsp_ channel, zero or one per byte, in the cycle after
// the byte is taken: the state machine is a single pass of logic between
// its state registers and the result register, so a byte is accepted in
// every cycle unless stalled. When the receiver stalls, the held result
// stays and the input is stalled only while that result waits; bytes that
// give no result still need the slot to be free or draining. Configuration
// is written through csr_write_enable, csr_index and csr_write_data; the
// user must do so only while no frame is in progress, as the block does
// not enforce it. Synchronous reset restores the default sync bytes (0xB5,
// 0x62), maximum length 1024, the hunting state and an empty result register.
`default_nettype none

module ubx_frame_parser_top (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [ubx_pkg::ByteWidth-1:0]     req_rx_byte,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [ubx_pkg::EventWidth-1:0]         rsp_event_res,
   output logic [ubx_pkg::ByteWidth-1:0]          rsp_msg_class,
   output logic [ubx_pkg::ByteWidth-1:0]          rsp_msg_id,
   output logic [ubx_pkg::WordWidth-1:0]          rsp_payload_length,
   output logic [ubx_pkg::WordWidth-1:0]          rsp_byte_index,
   output logic [ubx_pkg::ByteWidth-1:0]          rsp_byte_value,
   input  wire logic                              csr_write_enable,
   input  wire logic [ubx_pkg::CsrIdxWidth-1:0]   csr_index,
   input  wire logic [ubx_pkg::WordWidth-1:0]     csr_write_data
);
   import ubx_pkg::*;

   cfg_type    cfg;
   result_type res;
   result_type rsp_data;
   logic       res_valid;
   logic       accept;

   // A byte transfer completes when it is offered and not stalled.
   assign accept = req_valid & ~req_stall;

   ubx_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   ubx_parse_core u_core (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .rx_byte   (req_rx_byte),
      .cfg       (cfg),
      .res_valid (res_valid),
      .res       (res)
   );

   ubx_rsp_reg u_rsp (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .res_valid (res_valid),
      .res       (res),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .req_stall (req_stall)
   );

   // Unpack the held result onto the output ports.
   assign rsp_event_res      = rsp_data.event_res;
   assign rsp_msg_class      = rsp_data.msg_class;
   assign rsp_msg_id         = rsp_data.msg_id;
   assign rsp_payload_length = rsp_data.payload_length;
   assign rsp_byte_index     = rsp_data.byte_index;
   assign rsp_byte_value     = rsp_data.byte_value;

endmodule

`default_nettype wire
